FILE: src/imu_smoothing_gravity_removal_defines.svh
// Assertion macros for the IMU smoothing block
`ifndef IMU_SMOOTHING_GRAVITY_REMOVAL_DEFINES_SVH
`define IMU_SMOOTHING_GRAVITY_REMOVAL_DEFINES_SVH
// concurrent check, reset disables it
`define ISGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same check with no reset gating
`define ISGR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: src/isgr_pkg.sv
// Package: widths, codes, types and helpers for the IMU smoothing block
`timescale 1ns / 1ps
`default_nettype none
package isgr_pkg;
  localparam int SampleW = 32;
  localparam int QuatW   = 16;
  localparam int CountW  = 16;
  localparam int WeightW = 17;
  localparam int SumW    = 48;
  localparam int QFrac   = QuatW - 2;
  localparam int PFrac   = 2 * QFrac;
  localparam int EntW    = PFrac + 4;
  localparam int AccW    = 64;
  localparam int QDepth  = 2;
  localparam int QPtrW   = 1;
  localparam logic [WeightW-1:0] WeightOne = WeightW'(65536);

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_PUBLISH = 1'b1;
  localparam logic [0:0] CFG_WEIGHT = 1'b0;
  localparam logic [0:0] CFG_INIT   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SMOOTH, ST_DIVIDE, ST_MATRIX, ST_ROT, ST_EMIT0, ST_EMIT1
  } st_t;

  typedef struct packed {
    logic                            publish;
    logic signed [2:0][SampleW-1:0]  accel;
    logic signed [2:0][SampleW-1:0]  rate;
    logic signed [3:0][QuatW-1:0]    quat;
  } job_t;

  typedef struct packed {
    logic                            kind;
    logic signed [3:0][QuatW-1:0]    quat;
    logic signed [2:0][SampleW-1:0]  rate;
    logic signed [2:0][SampleW-1:0]  accel;
    logic                            last;
  } rec_t;

  function automatic logic signed [SampleW-1:0] sat_s(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'((64'sd1 <<< (SampleW - 1)) - 64'sd1);
    lo = -hi - AccW'(1);
    if (v > hi) return hi[SampleW-1:0];
    if (v < lo) return lo[SampleW-1:0];
    return v[SampleW-1:0];
  endfunction

  function automatic logic signed [EntW-1:0] clamp_e(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] lim;
    lim = AccW'(64'sd1 <<< (PFrac + 2));
    if (v > lim) return lim[EntW-1:0];
    if (v < -lim) return EntW'(-lim);
    return v[EntW-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: src/isgr_if.sv
// Valid/ready channel interfaces for the IMU smoothing block
`timescale 1ns / 1ps
`default_nettype none
interface isgr_job_if import isgr_pkg::*; ();
  logic valid;
  logic ready;
  job_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface isgr_rec_if import isgr_pkg::*; ();
  logic valid;
  logic ready;
  rec_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface isgr_cfg_if ();
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: src/isgr_front.sv
// Front end: accepts beats and queues them for the engine
`timescale 1ns / 1ps
`default_nettype none
module isgr_front import isgr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  isgr_job_if.sink   in_ch,
  output job_t       job,
  output logic       job_valid,
  input  wire logic  job_take
);
  job_t             q_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;
  logic             push;

  assign in_ch.ready = (cnt_r != (QPtrW+1)'(QDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign job_valid   = (cnt_r != '0);
  assign job         = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_ch.data;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (job_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(job_take);
    end
  end
endmodule
`default_nettype wire

FILE: src/isgr_divider.sv
// Restoring divider, one quotient bit per cycle, for the gravity mean
`timescale 1ns / 1ps
`default_nettype none
module isgr_divider import isgr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SumW-1:0]   num,
  input  wire logic [CountW-1:0] den,
  output logic                   busy,
  output logic [SumW-1:0]        quo
);
  logic [SumW-1:0]     n_r, q_r;
  logic [CountW:0]     rem_r;
  logic [CountW-1:0]   d_r;
  logic [$clog2(SumW+1)-1:0] k_r;
  logic [CountW+1:0]   trial;

  assign quo   = q_r;
  assign busy  = (k_r != '0);
  assign trial = {rem_r, n_r[SumW-1]} - {2'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (start) begin
      n_r <= num; d_r <= den; rem_r <= '0; q_r <= '0;
      k_r <= ($clog2(SumW+1))'(SumW);
    end else if (busy) begin
      n_r <= n_r << 1;
      k_r <= k_r - 1'b1;
      if (!trial[CountW+1]) begin
        rem_r <= trial[CountW:0];
        q_r   <= {q_r[SumW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[CountW-1:0], n_r[SumW-1]};
        q_r   <= {q_r[SumW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/isgr_engine.sv
// Back end: smoothing, gravity estimate, rotation with one shared multiplier
`timescale 1ns / 1ps
`default_nettype none
module isgr_engine import isgr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire job_t         job,
  input  wire logic         job_valid,
  output logic              job_take,
  input  wire logic [WeightW-1:0] weight,
  input  wire logic [CountW-1:0]  need,
  isgr_rec_if.source        out_ch
);
  st_t st_r, st_nxt;
  logic signed [2:0][SampleW-1:0] facc_r, frate_r, grav_r;
  logic signed [3:0][QuatW-1:0]   cq_r, rq_r;
  logic signed [2:0][SumW-1:0]    gsum_r;
  logic [CountW-1:0] gcnt_r;
  logic primed_r, gready_r;
  job_t j_r;
  logic [4:0] k_r;
  logic signed [8:0][EntW-1:0] ri_r, rc_r;
  logic signed [2:0][SampleW-1:0] v_r;
  logic signed [2:0][SampleW-1:0] gacc_r;
  logic signed [AccW-1:0] acc_r;
  logic [1:0] ax_r;

  rec_t rec_r;
  logic rvalid_r;
  assign out_ch.valid = rvalid_r;
  assign out_ch.data  = rec_r;

  // shared multiplier: smoothing 32x17, matrix 16x16, rotation 32x32
  logic signed [SampleW:0]   ma;
  logic signed [SampleW:0]   mb;
  logic signed [2*SampleW+1:0] mp;
  assign mp = ma * mb;

  logic [WeightW-1:0] w_eff;
  assign w_eff = (weight > WeightOne) ? WeightOne : weight;

  // divider
  logic div_start, div_busy;
  logic [SumW-1:0] div_num, div_quo;
  logic signed [SumW-1:0] sum_sel;
  logic [SumW-1:0] mag;
  assign sum_sel = gsum_r[ax_r];
  assign mag = sum_sel[SumW-1] ? SumW'(-sum_sel) : sum_sel;
  assign div_num = mag + SumW'(gcnt_r >> 1);
  isgr_divider u_div (.clk, .rst_n, .start(div_start), .num(div_num), .den(gcnt_r),
                      .busy(div_busy), .quo(div_quo));

  // sequencing of the smoothing phase: k 0..11, even step=(1-a)*avg, odd=a*x
  logic [2:0] sidx;
  logic signed [SampleW-1:0] s_old, s_new;
  always_comb begin
    sidx  = 3'(k_r[4:1]);
    s_old = (sidx < 3'd3) ? facc_r[sidx[1:0]] : frate_r[2'(sidx - 3'd3)];
    s_new = (sidx < 3'd3) ? j_r.accel[sidx[1:0]] : j_r.rate[2'(sidx - 3'd3)];
  end

  // matrix phase: k[3:0] 0..8 picks the products of the quaternion
  logic signed [QuatW-1:0] qa, qb;
  logic signed [3:0][QuatW-1:0] qsel;
  logic mat_cur;
  logic [3:0] pk;
  always_comb begin
    mat_cur = k_r[4];
    pk = k_r[3:0];
    qsel = mat_cur ? cq_r : rq_r;
    unique case (pk)
      4'd0: begin qa = qsel[2]; qb = qsel[2]; end
      4'd1: begin qa = qsel[3]; qb = qsel[3]; end
      4'd2: begin qa = qsel[1]; qb = qsel[1]; end
      4'd3: begin qa = qsel[1]; qb = qsel[2]; end
      4'd4: begin qa = qsel[0]; qb = qsel[3]; end
      4'd5: begin qa = qsel[1]; qb = qsel[3]; end
      4'd6: begin qa = qsel[0]; qb = qsel[2]; end
      4'd7: begin qa = qsel[2]; qb = qsel[3]; end
      4'd8: begin qa = qsel[0]; qb = qsel[1]; end
      default: begin qa = '0; qb = '0; end
    endcase
  end
  logic signed [8:0][AccW-1:0] pp_r;

  // rotation phase: k = 0..17; first 9 give v, next 9 give c
  logic rot2;
  logic [1:0] ri, rj;
  logic [3:0] rk;
  always_comb begin
    rot2 = (k_r >= 5'd9);
    rk = rot2 ? 4'(k_r - 5'd9) : k_r[3:0];
    ri = (rk < 4'd3) ? 2'd0 : (rk < 4'd6) ? 2'd1 : 2'd2;
    rj = 2'(rk - 4'(ri) * 4'd3);
  end

  logic signed [EntW-1:0] rot_e;
  logic signed [SampleW-1:0] rot_x;
  always_comb begin
    if (rot2) begin
      rot_e = rc_r[4'(rj) * 4'd3 + 4'(ri)];
      rot_x = v_r[rj];
    end else begin
      rot_e = ri_r[4'(ri) * 4'd3 + 4'(rj)];
      rot_x = grav_r[rj];
    end
  end

  always_comb begin
    ma = '0; mb = '0;
    unique case (st_r)
      ST_SMOOTH: begin
        if (!k_r[0]) begin
          ma = (SampleW+1)'(s_old);
          mb = (SampleW+1)'($signed({1'b0, WeightOne - w_eff}));
        end else begin
          ma = (SampleW+1)'(s_new);
          mb = (SampleW+1)'($signed({1'b0, w_eff}));
        end
      end
      ST_MATRIX: begin ma = (SampleW+1)'(qa); mb = (SampleW+1)'(qb); end
      ST_ROT:    begin ma = (SampleW+1)'(rot_e); mb = (SampleW+1)'(rot_x); end
      default: ;
    endcase
  end

  logic signed [AccW-1:0] one_p;
  assign one_p = AccW'(64'sd1 <<< PFrac);
  logic signed [AccW-1:0] rnd_half;
  assign rnd_half = AccW'(64'sd1 <<< (PFrac - 1));

  logic signed [AccW-1:0] sm_sum, rot_sum;
  assign sm_sum  = acc_r + AccW'(mp);
  assign rot_sum = acc_r + AccW'(mp);

  always_comb begin
    st_nxt = st_r;
    job_take = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      ST_IDLE: if (job_valid && !rvalid_r) begin
        job_take = 1'b1;
        if (job.publish == CMD_PUBLISH) st_nxt = primed_r ? ST_EMIT0 : ST_IDLE;
        else st_nxt = primed_r ? ST_SMOOTH : ST_IDLE;
      end
      ST_SMOOTH: if (k_r == 5'd11) begin
        st_nxt = ST_IDLE;
        if (!gready_r && ((CountW+1)'(gcnt_r) + 1'b1 >= (CountW+1)'(need)
            || need == '0)) st_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: if (k_r == 5'd0 && !div_busy) div_start = 1'b1;
        else if (!div_busy && k_r != 5'd0 && ax_r == 2'd2 && k_r[0]) st_nxt = ST_IDLE;
      ST_MATRIX: if (k_r == 5'd25) st_nxt = ST_ROT;
      ST_ROT: if (k_r == 5'd17) st_nxt = ST_EMIT1;
      ST_EMIT0: if (!rvalid_r) st_nxt = gready_r ? ST_MATRIX : ST_IDLE;
      ST_EMIT1: if (!rvalid_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; k_r <= '0; ax_r <= '0;
      primed_r <= 1'b0; gready_r <= 1'b0; gcnt_r <= '0; rvalid_r <= 1'b0;
      facc_r <= '0; frate_r <= '0; cq_r <= '0; gsum_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) rvalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          k_r <= '0; acc_r <= '0; ax_r <= '0;
          if (job_take) begin
            j_r <= job;
            if (job.publish == CMD_SAMPLE && !primed_r) begin
              facc_r <= job.accel; frate_r <= job.rate; cq_r <= job.quat;
              primed_r <= 1'b1;
            end
          end
        end
        ST_SMOOTH: begin
          if (!k_r[0]) acc_r <= AccW'(mp) + AccW'(64'sd32768);
          else begin
            if (sidx < 3'd3)
              facc_r[sidx[1:0]] <= sm_sum[16 +: SampleW];
            else
              frate_r[2'(sidx - 3'd3)] <= sm_sum[16 +: SampleW];
          end
          if (k_r == 5'd11) begin
            k_r <= '0;
            cq_r <= j_r.quat;
            if (!gready_r) begin
              for (int i = 0; i < 3; i++)
                gsum_r[i] <= gsum_r[i] + SumW'($signed(j_r.accel[i]));
              gcnt_r <= gcnt_r + 1'b1;
            end
          end else k_r <= k_r + 1'b1;
        end
        ST_DIVIDE: begin
          // k=0: start axis; k=1: wait finish, store, next axis
          if (k_r == 5'd0) begin
            if (!div_busy) k_r <= 5'd1;
          end else if (!div_busy) begin
            grav_r[ax_r] <= sat_s(sum_sel[SumW-1] ? -AccW'(div_quo) : AccW'(div_quo));
            k_r <= 5'd0;
            ax_r <= ax_r + 1'b1;
            if (ax_r == 2'd2) begin
              rq_r <= cq_r; gready_r <= 1'b1;
            end
          end
        end
        ST_MATRIX: begin
          // k 0..8 ref products, 9 ref matrix, 16..24 current products, 25 current matrix
          if (pk < 4'd9) pp_r[pk] <= AccW'(mp);
          if (k_r == 5'd9 || k_r == 5'd25) begin
            if (k_r == 5'd9) begin
              ri_r[0] <= clamp_e(one_p - 2*(pp_r[0] + pp_r[1]));
              ri_r[1] <= clamp_e(2*(pp_r[3] - pp_r[4]));
              ri_r[2] <= clamp_e(2*(pp_r[5] + pp_r[6]));
              ri_r[3] <= clamp_e(2*(pp_r[3] + pp_r[4]));
              ri_r[4] <= clamp_e(one_p - 2*(pp_r[2] + pp_r[1]));
              ri_r[5] <= clamp_e(2*(pp_r[7] - pp_r[8]));
              ri_r[6] <= clamp_e(2*(pp_r[5] - pp_r[6]));
              ri_r[7] <= clamp_e(2*(pp_r[7] + pp_r[8]));
              ri_r[8] <= clamp_e(one_p - 2*(pp_r[2] + pp_r[0]));
              k_r <= 5'd16;
            end else begin
              k_r <= '0; acc_r <= '0;
            end
          end else k_r <= k_r + 1'b1;
          if (k_r == 5'd25) begin
            rc_r[0] <= clamp_e(one_p - 2*(pp_r[0] + pp_r[1]));
            rc_r[1] <= clamp_e(2*(pp_r[3] - pp_r[4]));
            rc_r[2] <= clamp_e(2*(pp_r[5] + pp_r[6]));
            rc_r[3] <= clamp_e(2*(pp_r[3] + pp_r[4]));
            rc_r[4] <= clamp_e(one_p - 2*(pp_r[2] + pp_r[1]));
            rc_r[5] <= clamp_e(2*(pp_r[7] - pp_r[8]));
            rc_r[6] <= clamp_e(2*(pp_r[5] - pp_r[6]));
            rc_r[7] <= clamp_e(2*(pp_r[7] + pp_r[8]));
            rc_r[8] <= clamp_e(one_p - 2*(pp_r[2] + pp_r[0]));
          end
        end
        ST_ROT: begin
          if (rj == 2'd2) begin
            acc_r <= '0;
            if (!rot2) v_r[ri] <= sat_s((rot_sum + rnd_half) >>> PFrac);
            else gacc_r[ri] <= sat_s(AccW'($signed(facc_r[ri]))
                                 - ((rot_sum + rnd_half) >>> PFrac));
          end else acc_r <= rot_sum;
          k_r <= k_r + 1'b1;
        end
        ST_EMIT0: if (!rvalid_r) begin
          rec_r.kind <= 1'b0; rec_r.quat <= cq_r; rec_r.rate <= frate_r;
          rec_r.accel <= facc_r; rec_r.last <= !gready_r; rvalid_r <= 1'b1;
          k_r <= '0;
        end
        ST_EMIT1: if (!rvalid_r) begin
          rec_r.kind <= 1'b1; rec_r.quat <= cq_r; rec_r.rate <= frate_r;
          rec_r.accel <= gacc_r; rec_r.last <= 1'b1; rvalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/imu_smoothing_gravity_removal.sv
// Top level of the IMU smoothing and gravity removal block
// A sample passes through the engine as a take and 12 multiplier steps on the
// one shared multiplier; the sample that completes the gravity estimate adds
// three 48-bit serial divisions. After gravity is known, a publish also builds
// two rotation matrices and runs 18 multiply-accumulates on the shared
// multiplier, and the receiver can stall each record. A 2-entry queue sits in
// front of the engine; the result register holds one record at a time.
`timescale 1ns / 1ps
`default_nettype none
module imu_smoothing_gravity_removal import isgr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  isgr_job_if.sink  in_ch,
  isgr_rec_if.source out_ch,
  isgr_cfg_if.sink  cfg_ch
);
  logic [WeightW-1:0] weight_r;
  logic [CountW-1:0]  need_r;
  job_t job;
  logic job_valid, job_take;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WeightW'(19661);
      need_r   <= CountW'(2500);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_WEIGHT: weight_r <= cfg_ch.wdata[WeightW-1:0];
        CFG_INIT:   need_r   <= cfg_ch.wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  isgr_front u_front (.clk, .rst_n, .in_ch, .job, .job_valid, .job_take);
  isgr_engine u_eng (.clk, .rst_n, .job, .job_valid, .job_take,
                     .weight(weight_r), .need(need_r), .out_ch);
endmodule
`default_nettype wire

FILE: src/isgr_checker.sv
// Port-level checker for the IMU smoothing block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "imu_smoothing_gravity_removal_defines.svh"
module isgr_checker import isgr_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic ov,
  input wire logic ordy,
  input wire rec_t od
);
  `ISGR_ASSERT(a_hold, ov && !ordy |=> ov && $stable(od), "result dropped while stalled")
  `ISGR_ASSERT(a_kind_last, ov && od.kind |-> od.last, "gravity record must be last")
  `ISGR_ASSERT(a_pair, ov && ordy && !od.last |=> !ov || od.kind, "record pair out of order")
  `ISGR_ASSERT_ALWAYS(a_rst, !rst_n |=> !ov, "result valid out of reset")
endmodule

bind imu_smoothing_gravity_removal isgr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .ov(out_ch.valid), .ordy(out_ch.ready), .od(out_ch.data));
`default_nettype wire

FILE: test/tb_imu_smoothing_gravity_removal.sv
// Self-checking testbench for the IMU smoothing and gravity removal block
`timescale 1ns / 1ps
module tb_imu_smoothing_gravity_removal;
  import isgr_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  isgr_job_if in_ch ();
  isgr_rec_if out_ch ();
  isgr_cfg_if cfg_ch ();

  imu_smoothing_gravity_removal u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  longint filt_acc[3], filt_rate[3], cur_q[4], grav_sum[3], grav_vec[3], ref_q[4];
  longint grav_cnt, weight_reg, init_reg;
  bit primed, grav_ready;

  rec_t expected_recs[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rshift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_ent(input longint v);
    longint lim;
    lim = 64'sd1 <<< (PFrac + 2);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  task automatic build_rot(input longint q[4], output longint r[9]);
    longint w, x, y, z, one;
    w = q[0]; x = q[1]; y = q[2]; z = q[3];
    one = 64'sd1 <<< PFrac;
    r[0] = one - 2 * (y * y + z * z);
    r[1] = 2 * (x * y - w * z);
    r[2] = 2 * (x * z + w * y);
    r[3] = 2 * (x * y + w * z);
    r[4] = one - 2 * (x * x + z * z);
    r[5] = 2 * (y * z - w * x);
    r[6] = 2 * (x * z - w * y);
    r[7] = 2 * (y * z + w * x);
    r[8] = one - 2 * (x * x + y * y);
    for (int i = 0; i < 9; i++) r[i] = clamp_ent(r[i]);
  endtask

  function automatic rec_t make_rec(input logic kind, input longint acc[3], input logic last);
    rec_t r;
    r.kind = kind;
    for (int i = 0; i < 4; i++) r.quat[i] = cur_q[i][QuatW-1:0];
    for (int i = 0; i < 3; i++) begin
      r.rate[i] = filt_rate[i][SampleW-1:0];
      r.accel[i] = acc[i][SampleW-1:0];
    end
    r.last = last;
    return r;
  endfunction

  task automatic predict_records(input job_t j);
    longint a[3], rt[3], rref[9], rcur[9], v[3], acc[3], s, w, need, mag, qt;
    if (j.publish == CMD_PUBLISH) begin
      if (!primed) return;
      expected_recs.push_back(make_rec(1'b0, filt_acc, !grav_ready));
      if (!grav_ready) return;
      build_rot(ref_q, rref);
      build_rot(cur_q, rcur);
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int k = 0; k < 3; k++) s += rref[i*3+k] * grav_vec[k];
        v[i] = sat32(rshift(s, PFrac));
      end
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int k = 0; k < 3; k++) s += rcur[k*3+i] * v[k];
        acc[i] = sat32(filt_acc[i] - rshift(s, PFrac));
      end
      expected_recs.push_back(make_rec(1'b1, acc, 1'b1));
      return;
    end
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(j.accel[i]));
      rt[i] = longint'($signed(j.rate[i]));
    end
    if (!primed) begin
      filt_acc = a;
      filt_rate = rt;
      for (int i = 0; i < 4; i++) cur_q[i] = longint'($signed(j.quat[i]));
      primed = 1'b1;
      return;
    end
    w = weight_reg > 65536 ? 65536 : weight_reg;
    for (int i = 0; i < 3; i++) begin
      filt_acc[i] = rshift((65536 - w) * filt_acc[i] + w * a[i], 16);
      filt_rate[i] = rshift((65536 - w) * filt_rate[i] + w * rt[i], 16);
    end
    for (int i = 0; i < 4; i++) cur_q[i] = longint'($signed(j.quat[i]));
    if (!grav_ready) begin
      need = init_reg == 0 ? 1 : init_reg;
      for (int i = 0; i < 3; i++) grav_sum[i] += a[i];
      grav_cnt = (grav_cnt + 1) & 16'hffff;
      if (grav_cnt >= need) begin
        for (int i = 0; i < 3; i++) begin
          mag = grav_sum[i] < 0 ? -grav_sum[i] : grav_sum[i];
          qt = (mag + grav_cnt / 2) / grav_cnt;
          grav_vec[i] = sat32(grav_sum[i] < 0 ? -qt : qt);
        end
        ref_q = cur_q;
        grav_ready = 1'b1;
      end
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    rec_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_recs.size() == 0) begin
        report("unexpected record", got.kind, 0);
      end else begin
        want = expected_recs.pop_front();
        if (got.kind !== want.kind) report("kind", got.kind, want.kind);
        if (got.last !== want.last) report("last", got.last, want.last);
        for (int i = 0; i < 4; i++)
          if (got.quat[i] !== want.quat[i]) report($sformatf("quat[%0d]", i), got.quat[i], want.quat[i]);
        for (int i = 0; i < 3; i++) begin
          if (got.rate[i] !== want.rate[i]) report($sformatf("rate[%0d]", i), got.rate[i], want.rate[i]);
          if (got.accel[i] !== want.accel[i]) report($sformatf("accel[%0d]", i), got.accel[i], want.accel[i]);
        end
      end
    end
  end

  // one beat on the input channel; valid stays high across back-to-back beats
  task automatic send_job(input job_t j);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= j;
    do @(posedge clk); while (!in_ch.ready);
    predict_records(j);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_WEIGHT) weight_reg = val & 32'h1ffff;
    else init_reg = val & 32'hffff;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic job_t rand_sample();
    job_t j;
    j.publish = CMD_SAMPLE;
    for (int i = 0; i < 3; i++) begin
      j.accel[i] = rand_word();
      j.rate[i] = rand_word();
    end
    for (int i = 0; i < 4; i++)
      j.quat[i] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
    return j;
  endfunction

  function automatic job_t publish_job();
    job_t j;
    j = rand_sample();
    j.publish = CMD_PUBLISH;
    return j;
  endfunction

  task automatic test_early_publish();
    send_job(publish_job());
    send_job(rand_sample());
    send_job(publish_job());
    wait_idle();
  endtask

  task automatic test_weight_extremes();
    job_t j;
    write_reg(CFG_INIT, 32'd65535);
    write_reg(CFG_WEIGHT, 32'd0);
    send_job(rand_sample());
    send_job(publish_job());
    wait_idle();
    write_reg(CFG_WEIGHT, 32'd65536);
    j = rand_sample();
    for (int i = 0; i < 3; i++) j.accel[i] = 32'h7fffffff;
    send_job(j);
    send_job(publish_job());
    wait_idle();
    write_reg(CFG_WEIGHT, 32'h1ffff);
    j = rand_sample();
    for (int i = 0; i < 3; i++) j.accel[i] = 32'h80000000;
    for (int i = 0; i < 4; i++) j.quat[i] = 16'h8000;
    send_job(j);
    send_job(publish_job());
    wait_idle();
  endtask

  // init lowered below the running count: gravity completes on the next sample
  task automatic test_gravity_capture();
    job_t j;
    write_reg(CFG_WEIGHT, 32'd19661);
    send_job(rand_sample());
    wait_idle();
    write_reg(CFG_INIT, 32'd0);
    j = rand_sample();
    for (int i = 0; i < 4; i++) j.quat[i] = 16'h7fff;
    send_job(j);
    send_job(publish_job());
    send_job(rand_sample());
    send_job(publish_job());
    wait_idle();
  endtask

  task automatic test_random(input int n, input int sidle, input int rstall, input int wgt);
    write_reg(CFG_WEIGHT, wgt);
    write_reg(CFG_INIT, $urandom_range(1, 65535));
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int k = 0; k < n; k++) send_job($urandom_range(99) < 65 ? rand_sample() : publish_job());
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      filt_acc[i] = 0; filt_rate[i] = 0; grav_sum[i] = 0; grav_vec[i] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      cur_q[i] = 0; ref_q[i] = 0;
    end
    grav_cnt = 0; primed = 0; grav_ready = 0;
    weight_reg = 19661; init_reg = 2500;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_WEIGHT;
    cfg_ch.wdata = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_early_publish();
    test_weight_extremes();
    test_gravity_capture();
    test_random(570, 13, 81, $urandom_range(0, 65536));
    test_random(570, 81, 13, $urandom_range(65536, 131071));
    test_random(570, 0, 0, $urandom_range(0, 65536));

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
